>>> sv/modexp_pkg.sv
`timescale 1ns / 1ps
package modexp_pkg;

	// Width of the item fields and configuration registers
	localparam int unsigned FIELD_W = 32;

	// Configuration register indexes
	localparam logic CFG_MODULUS  = 1'b0;
	localparam logic CFG_EXPONENT = 1'b1;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_SKIP   = 6'b000100,
		ST_SQUARE = 6'b001000,
		ST_MULT   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

endpackage

>>> sv/modular_exponentiation_top.sv
`timescale 1ns / 1ps
// Left-to-right square-and-multiply; each modular product runs through a row of
// MOD_WIDTH cells. One item in flight at a time.
// Reset (arst_n low, asynchronous): modulus 1, exponent 1, sequencer idle, no result.
module modular_exponentiation_top #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [modexp_pkg::FIELD_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [modexp_pkg::FIELD_W-1:0]     base_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [modexp_pkg::FIELD_W-1:0]     power_result
);
	import modexp_pkg::*;

	state_t               state_q;
	logic [FIELD_W-1:0]   modulus_q, exponent_q;
	logic [FIELD_W-1:0]   e_q;
	logic [4:0]           cnt_q;
	logic                 issued_q;
	logic [MOD_WIDTH-1:0] base_q, acc_q;
	logic                 out_valid_q;
	logic [FIELD_W-1:0]   result_q;

	logic [MOD_WIDTH+FIELD_W-1:0] base_ext, mod_wide, acc_wide;
	logic [MOD_WIDTH-1:0] mod_w;
	logic [MOD_WIDTH:0]   mod_ext;
	logic                 in_acc, out_free;
	logic                 mul_start, mul_done;
	logic [MOD_WIDTH-1:0] op_a, op_b, product;

	// Field to datapath width conversions
	assign base_ext = {{MOD_WIDTH{1'b0}}, base_value};
	assign mod_wide = {{MOD_WIDTH{1'b0}}, modulus_q};
	assign acc_wide = {{FIELD_W{1'b0}}, acc_q};
	assign mod_w    = mod_wide[MOD_WIDTH-1:0];
	// Modulus zero stands for 2^MOD_WIDTH
	assign mod_ext  = (mod_w == '0) ? {1'b1, {MOD_WIDTH{1'b0}}} : {1'b0, mod_w};

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Operand select for the multiplier row
	always_comb begin
		op_a = acc_q;
		op_b = acc_q;
		case (state_q)
			ST_REDUCE: begin
				op_a = MOD_WIDTH'(1);
				op_b = base_q;
			end
			ST_MULT: begin
				op_a = base_q;
				op_b = acc_q;
			end
			default: begin
				op_a = acc_q;
				op_b = acc_q;
			end
		endcase
	end

	assign mul_start = !issued_q &&
		(state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT);

	modexp_mulchain #(.MOD_WIDTH(MOD_WIDTH)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.mod_ext(mod_ext),
		.start  (mul_start),
		.op_a   (op_a),
		.op_b   (op_b),
		.done   (mul_done),
		.product(product)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= FIELD_W'(1);
			exponent_q <= FIELD_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS:  modulus_q  <= cfg_data;
				CFG_EXPONENT: exponent_q <= cfg_data;
				default:      modulus_q  <= modulus_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (mul_start)
				issued_q <= 1'b1;
			else if (mul_done)
				issued_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= (exponent_q == '0) ? ST_FINISH : ST_REDUCE;
				end
				ST_REDUCE: begin
					if (mul_done)
						state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (e_q[FIELD_W-1])
						state_q <= (cnt_q == '0) ? ST_FINISH : ST_SQUARE;
				end
				ST_SQUARE: begin
					if (mul_done) begin
						if (e_q[FIELD_W-1])
							state_q <= ST_MULT;
						else if (cnt_q == 5'd1)
							state_q <= ST_FINISH;
					end
				end
				ST_MULT: begin
					if (mul_done)
						state_q <= (cnt_q == '0) ? ST_FINISH : ST_SQUARE;
				end
				ST_FINISH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					base_q <= base_ext[MOD_WIDTH-1:0];
					acc_q  <= MOD_WIDTH'(1);
					e_q    <= exponent_q;
					cnt_q  <= 5'd31;
				end
			end
			ST_REDUCE: begin
				if (mul_done) begin
					base_q <= product;
					acc_q  <= product;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, then step past the top set bit
				e_q <= {e_q[FIELD_W-2:0], 1'b0};
				if (!e_q[FIELD_W-1])
					cnt_q <= cnt_q - 5'd1;
			end
			ST_SQUARE: begin
				if (mul_done) begin
					acc_q <= product;
					e_q   <= {e_q[FIELD_W-2:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
				end
			end
			ST_MULT: begin
				if (mul_done)
					acc_q <= product;
			end
			ST_FINISH: begin
				if (out_free)
					result_q <= acc_wide[FIELD_W-1:0];
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign power_result = result_q;

endmodule

>>> sv/modexp_cell.sv
`timescale 1ns / 1ps
module modexp_cell #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MOD_WIDTH:0]   mod_ext,
	input  logic                 v_in,
	input  logic [MOD_WIDTH-1:0] r_in,
	input  logic [MOD_WIDTH-1:0] a_in,
	input  logic [MOD_WIDTH-1:0] b_in,
	output logic                 v_out,
	output logic [MOD_WIDTH-1:0] r_out,
	output logic [MOD_WIDTH-1:0] a_out,
	output logic [MOD_WIDTH-1:0] b_out
);

	logic [MOD_WIDTH:0]   dbl_sum;
	logic [MOD_WIDTH-1:0] dbl;
	logic [MOD_WIDTH:0]   add_sum;
	logic [MOD_WIDTH-1:0] nxt;
	logic                 v_q;
	logic [MOD_WIDTH-1:0] r_q, a_q, b_q;

	// One double-and-add step, each sum folded back below the modulus
	always_comb begin
		dbl_sum = {1'b0, r_in} + {1'b0, r_in};
		if (dbl_sum >= mod_ext)
			dbl_sum = dbl_sum - mod_ext;
		dbl = dbl_sum[MOD_WIDTH-1:0];
		add_sum = {1'b0, dbl} + {1'b0, a_in};
		if (add_sum >= mod_ext)
			add_sum = add_sum - mod_ext;
		nxt = b_in[MOD_WIDTH-1] ? add_sum[MOD_WIDTH-1:0] : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else
			v_q <= v_in;
	end

	always_ff @(posedge clk) begin
		r_q <= nxt;
		a_q <= a_in;
		b_q <= {b_in[MOD_WIDTH-2:0], 1'b0};
	end

	assign v_out = v_q;
	assign r_out = r_q;
	assign a_out = a_q;
	assign b_out = b_q;

endmodule

>>> sv/modexp_mulchain.sv
`timescale 1ns / 1ps
module modexp_mulchain #(
	parameter int unsigned MOD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MOD_WIDTH:0]   mod_ext,
	input  logic                 start,
	input  logic [MOD_WIDTH-1:0] op_a,
	input  logic [MOD_WIDTH-1:0] op_b,
	output logic                 done,
	output logic [MOD_WIDTH-1:0] product
);

	logic                 v_link [0:MOD_WIDTH];
	logic [MOD_WIDTH-1:0] r_link [0:MOD_WIDTH];
	logic [MOD_WIDTH-1:0] a_link [0:MOD_WIDTH];
	logic [MOD_WIDTH-1:0] b_link [0:MOD_WIDTH];

	assign v_link[0] = start;
	assign r_link[0] = '0;
	assign a_link[0] = op_a;
	assign b_link[0] = op_b;

	// One cell per multiplier bit, msb first
	for (genvar i = 0; i < MOD_WIDTH; i++) begin : g_cell
		modexp_cell #(.MOD_WIDTH(MOD_WIDTH)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.mod_ext(mod_ext),
			.v_in   (v_link[i]),
			.r_in   (r_link[i]),
			.a_in   (a_link[i]),
			.b_in   (b_link[i]),
			.v_out  (v_link[i+1]),
			.r_out  (r_link[i+1]),
			.a_out  (a_link[i+1]),
			.b_out  (b_link[i+1])
		);
	end

	assign done    = v_link[MOD_WIDTH];
	assign product = r_link[MOD_WIDTH];

endmodule

>>> sv/modexp_checker.sv
`timescale 1ns / 1ps
module modexp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [modexp_pkg::FIELD_W-1:0] power_result
);
	import modexp_pkg::*;

	// A held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(power_result))
		else $error("result changed while stalled");

	// Block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted during work");

	// No result can appear in the cycle right after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.power_result(power_result)
);
